// ===== hdl/quaternion_orientation_integrator_unit_assert.svh =====
// Assertion macros for the quaternion orientation integrator checker.
`ifndef QUATERNION_ORIENTATION_INTEGRATOR_UNIT_ASSERT_SVH
`define QUATERNION_ORIENTATION_INTEGRATOR_UNIT_ASSERT_SVH

// Condition implies consequence in the same cycle, outside reset.
`define QOI_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("qoi assertion failed");

// Condition implies consequence in the next cycle, outside reset.
`define QOI_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("qoi assertion failed");

// Condition implies consequence in the next cycle, also checked during reset.
`define QOI_ASSERT_NEXT_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("qoi assertion failed");

`endif

// ===== hdl/qoi_pkg.sv =====
// Package with the types, constants and tables of the quaternion integrator.
`default_nettype none
package qoi_pkg;

  localparam int QOI_COMPONENT_WIDTH = 32;
  localparam int QOI_NORM_ITERATIONS = 4;

  localparam logic [30:0] SEED_SMALL_M = 31'd912680550;
  localparam logic [30:0] SEED_LARGE_M = 31'd644245094;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_SQ,
    OP_SQ_ACC,
    OP_NORM_INIT,
    OP_NORM_STEP,
    OP_SEED,
    OP_NT_A,
    OP_NT_B,
    OP_NT_C,
    OP_NT_D,
    OP_NT_E,
    OP_NT_F,
    OP_SC_MUL,
    OP_SC_WR,
    OP_ZERO,
    OP_RT_MUL,
    OP_RT_ACC,
    OP_DT_HI_MUL,
    OP_DT_HI,
    OP_DT_LO_MUL,
    OP_DT_WR,
    OP_COMMIT
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_NORM_INIT,
    ST_NORM,
    ST_SEED,
    ST_NT_A,
    ST_NT_B,
    ST_NT_C,
    ST_NT_D,
    ST_NT_E,
    ST_NT_F,
    ST_SC_MUL,
    ST_SC_WR,
    ST_ZERO,
    ST_RT_MUL,
    ST_RT_ACC,
    ST_DT_HI_MUL,
    ST_DT_HI,
    ST_DT_LO_MUL,
    ST_DT_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] idx;
    logic [1:0] term;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic all_zero;
    logic norm_done;
  } stat_t;

  typedef struct packed {
    logic [1:0] a_idx;
    logic [1:0] w_idx;
    logic       neg;
  } rt_sel_t;

  // Operand selection of the Hamilton product q * (0, wx, wy, wz).
  function automatic rt_sel_t rt_sel(input logic [1:0] comp, input logic [1:0] term);
    rt_sel_t s;
    s = '0;
    unique case ({comp, term})
      4'b0000: s = '{a_idx: 2'd1, w_idx: 2'd0, neg: 1'b1};
      4'b0001: s = '{a_idx: 2'd2, w_idx: 2'd1, neg: 1'b1};
      4'b0010: s = '{a_idx: 2'd3, w_idx: 2'd2, neg: 1'b1};
      4'b0100: s = '{a_idx: 2'd0, w_idx: 2'd0, neg: 1'b0};
      4'b0101: s = '{a_idx: 2'd2, w_idx: 2'd2, neg: 1'b0};
      4'b0110: s = '{a_idx: 2'd3, w_idx: 2'd1, neg: 1'b1};
      4'b1000: s = '{a_idx: 2'd0, w_idx: 2'd1, neg: 1'b0};
      4'b1001: s = '{a_idx: 2'd3, w_idx: 2'd0, neg: 1'b0};
      4'b1010: s = '{a_idx: 2'd1, w_idx: 2'd2, neg: 1'b1};
      4'b1100: s = '{a_idx: 2'd0, w_idx: 2'd2, neg: 1'b0};
      4'b1101: s = '{a_idx: 2'd1, w_idx: 2'd1, neg: 1'b0};
      4'b1110: s = '{a_idx: 2'd2, w_idx: 2'd0, neg: 1'b1};
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/qoi_ctrl.sv =====
// Controller state machine that sequences the integrator datapath.
`default_nettype none
module qoi_ctrl #(
  parameter int NORM_ITERATIONS = qoi_pkg::QOI_NORM_ITERATIONS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  qoi_pkg::stat_t stat,
  output qoi_pkg::cmd_t  cmd
);
  import qoi_pkg::*;

  localparam int IW = (NORM_ITERATIONS > 1) ? $clog2(NORM_ITERATIONS) : 1;

  state_t        state_r, state_nxt;
  logic [1:0]    idx_r, idx_nxt;
  logic [1:0]    term_r, term_nxt;
  logic [IW-1:0] iter_r, iter_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    term_nxt  = term_r;
    iter_nxt  = iter_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        idx_nxt  = 2'd0;
        term_nxt = 2'd0;
        priority if (stat.kind) begin
          state_nxt = ST_RT_MUL;
        end else if (stat.all_zero) begin
          state_nxt = ST_ZERO;
        end else begin
          state_nxt = ST_SQ_MUL;
        end
      end
      ST_SQ_MUL: state_nxt = ST_SQ_ACC;
      ST_SQ_ACC: begin
        if (idx_r == 2'd3) begin
          state_nxt = ST_NORM_INIT;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = ST_SQ_MUL;
        end
      end
      ST_NORM_INIT: state_nxt = ST_NORM;
      ST_NORM: begin
        if (stat.norm_done) begin
          state_nxt = ST_SEED;
        end
      end
      ST_SEED: begin
        iter_nxt  = '0;
        state_nxt = ST_NT_A;
      end
      ST_NT_A: state_nxt = ST_NT_B;
      ST_NT_B: state_nxt = ST_NT_C;
      ST_NT_C: state_nxt = ST_NT_D;
      ST_NT_D: state_nxt = ST_NT_E;
      ST_NT_E: state_nxt = ST_NT_F;
      ST_NT_F: begin
        if (iter_r == IW'(NORM_ITERATIONS - 1)) begin
          idx_nxt   = 2'd0;
          state_nxt = ST_SC_MUL;
        end else begin
          iter_nxt  = iter_r + 1'b1;
          state_nxt = ST_NT_A;
        end
      end
      ST_SC_MUL: state_nxt = ST_SC_WR;
      ST_SC_WR: begin
        if (idx_r == 2'd3) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = ST_SC_MUL;
        end
      end
      ST_ZERO: state_nxt = ST_DONE;
      ST_RT_MUL: state_nxt = ST_RT_ACC;
      ST_RT_ACC: begin
        if (term_r == 2'd2) begin
          term_nxt  = 2'd0;
          state_nxt = ST_DT_HI_MUL;
        end else begin
          term_nxt  = term_r + 2'd1;
          state_nxt = ST_RT_MUL;
        end
      end
      ST_DT_HI_MUL: state_nxt = ST_DT_HI;
      ST_DT_HI:     state_nxt = ST_DT_LO_MUL;
      ST_DT_LO_MUL: state_nxt = ST_DT_WR;
      ST_DT_WR: begin
        if (idx_r == 2'd3) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = ST_RT_MUL;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.idx       = idx_r;
    cmd.term      = term_r;
    cmd.op        = OP_NONE;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_LATCH;
        end
      end
      ST_SQ_MUL:    cmd.op = OP_SQ;
      ST_SQ_ACC:    cmd.op = OP_SQ_ACC;
      ST_NORM_INIT: cmd.op = OP_NORM_INIT;
      ST_NORM:      cmd.op = stat.norm_done ? OP_NONE : OP_NORM_STEP;
      ST_SEED:      cmd.op = OP_SEED;
      ST_NT_A:      cmd.op = OP_NT_A;
      ST_NT_B:      cmd.op = OP_NT_B;
      ST_NT_C:      cmd.op = OP_NT_C;
      ST_NT_D:      cmd.op = OP_NT_D;
      ST_NT_E:      cmd.op = OP_NT_E;
      ST_NT_F:      cmd.op = OP_NT_F;
      ST_SC_MUL:    cmd.op = OP_SC_MUL;
      ST_SC_WR:     cmd.op = OP_SC_WR;
      ST_ZERO:      cmd.op = OP_ZERO;
      ST_RT_MUL:    cmd.op = OP_RT_MUL;
      ST_RT_ACC:    cmd.op = OP_RT_ACC;
      ST_DT_HI_MUL: cmd.op = OP_DT_HI_MUL;
      ST_DT_HI:     cmd.op = OP_DT_HI;
      ST_DT_LO_MUL: cmd.op = OP_DT_LO_MUL;
      ST_DT_WR:     cmd.op = OP_DT_WR;
      ST_DONE: begin
        if (out_free) begin
          cmd.op        = OP_COMMIT;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      term_r      <= '0;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      term_r      <= term_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== hdl/qoi_datapath.sv =====
// Datapath with the shared multiplier, accumulator and orientation registers.
`default_nettype none
module qoi_datapath #(
  parameter int COMPONENT_WIDTH = qoi_pkg::QOI_COMPONENT_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  qoi_pkg::cmd_t       cmd,
  output qoi_pkg::stat_t      stat,
  input  logic                in_kind,
  input  logic signed [31:0]  in_comp_real,
  input  logic signed [31:0]  in_comp_i,
  input  logic signed [31:0]  in_comp_j,
  input  logic signed [31:0]  in_comp_k,
  input  logic signed [31:0]  in_omega_x,
  input  logic signed [31:0]  in_omega_y,
  input  logic signed [31:0]  in_omega_z,
  input  logic        [23:0]  in_step_time,
  output logic signed [31:0]  out_real,
  output logic signed [31:0]  out_i,
  output logic signed [31:0]  out_j,
  output logic signed [31:0]  out_k,
  output logic                out_was_zero,
  output logic                out_saturated
);
  import qoi_pkg::*;

  localparam int SW = (COMPONENT_WIDTH < 32) ? COMPONENT_WIDTH : 32;
  localparam int PW = 66;

  typedef logic signed [PW-1:0] wide_t;

  localparam wide_t CMAX = {{(PW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam wide_t CMIN = {{(PW-SW+1){1'b1}}, {(SW-1){1'b0}}};
  localparam wide_t ONE_Q30 = wide_t'(1) <<< 30;
  localparam logic [33:0] THREE_Q30 = 34'd3 << 30;

  logic                 kind_r;
  logic signed [31:0]   c_r [4];
  logic signed [31:0]   w_r [3];
  logic [23:0]          dt_r;
  logic signed [SW-1:0] q_r [4];
  logic signed [SW-1:0] nq_r [4];
  wide_t                acc_r;
  wide_t                prod_r;
  logic [63:0]          dn_r;
  logic signed [6:0]    sh_r;
  logic [31:0]          m_r;
  logic [30:0]          y_r;
  logic [31:0]          tmp_r;
  logic [5:0]           rsh_r;
  logic [47:0]          hi_r;
  logic                 wz_r;
  logic                 sat_r;
  logic                 out_zero_r;
  logic                 out_sat_r;

  logic signed [32:0] mul_a, mul_b;
  wide_t              prod_full;
  logic [32:0]        cmag [4];
  logic               big;
  logic [47:0]        accmag;
  rt_sel_t            sel;
  wide_t              rt_term;
  logic [33:0]        nt_t;
  logic [31:0]        nt_q;
  logic [63:0]        sc_v;
  wide_t              sc_s;
  logic [48:0]        dt_sum;
  wide_t              dt_inc;
  wide_t              dt_new;
  logic signed [7:0]  half_sh;
  wide_t              acc_abs;

  function automatic logic [32:0] mag32(input logic signed [31:0] x);
    logic signed [32:0] xe;
    xe = {x[31], x};
    return xe[32] ? 33'(-xe) : 33'(xe);
  endfunction

  function automatic logic signed [SW-1:0] clip_val(input wide_t x);
    if (x > CMAX) begin
      return CMAX[SW-1:0];
    end else if (x < CMIN) begin
      return CMIN[SW-1:0];
    end
    return x[SW-1:0];
  endfunction

  function automatic logic clip_ovf(input wide_t x);
    return (x > CMAX) || (x < CMIN);
  endfunction

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      cmag[n] = mag32(c_r[n]);
    end
    big = (cmag[0][32:30] != 3'd0) || (cmag[1][32:30] != 3'd0) ||
          (cmag[2][32:30] != 3'd0) || (cmag[3][32:30] != 3'd0);
  end

  assign stat.kind      = kind_r;
  assign stat.all_zero  = (c_r[0] == 32'sd0) && (c_r[1] == 32'sd0) &&
                          (c_r[2] == 32'sd0) && (c_r[3] == 32'sd0);
  assign stat.norm_done = (dn_r[63:62] == 2'b00) && (dn_r[61:60] != 2'b00);

  assign acc_abs = acc_r[PW-1] ? -acc_r : acc_r;
  assign accmag  = acc_abs[47:0];
  assign sel     = rt_sel(cmd.idx, cmd.term);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_SQ: begin
        mul_a = cmag[cmd.idx];
        mul_b = cmag[cmd.idx];
      end
      OP_NT_A: begin
        mul_a = {2'b00, y_r};
        mul_b = {2'b00, y_r};
      end
      OP_NT_C: begin
        mul_a = {1'b0, m_r};
        mul_b = {1'b0, tmp_r};
      end
      OP_NT_E: begin
        mul_a = {2'b00, y_r};
        mul_b = {1'b0, tmp_r};
      end
      OP_SC_MUL: begin
        mul_a = cmag[cmd.idx];
        mul_b = {2'b00, y_r};
      end
      OP_RT_MUL: begin
        mul_a = 33'(q_r[sel.a_idx]);
        mul_b = 33'(w_r[sel.w_idx]);
      end
      OP_DT_HI_MUL: begin
        mul_a = {9'd0, accmag[47:24]};
        mul_b = {9'd0, dt_r};
      end
      OP_DT_LO_MUL: begin
        mul_a = {9'd0, accmag[23:0]};
        mul_b = {9'd0, dt_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_full = wide_t'(mul_a) * wide_t'(mul_b);

  always_comb begin
    rt_term = prod_r >>> 16;
    if (sel.neg) begin
      rt_term = -rt_term;
    end
    nt_t    = prod_r[63:30];
    nt_q    = prod_r[62:31];
    sc_v    = prod_r[63:0] >> rsh_r;
    sc_s    = c_r[cmd.idx][31] ? -wide_t'({2'b00, sc_v}) : wide_t'({2'b00, sc_v});
    dt_sum  = {1'b0, hi_r} + 49'(prod_r[47:24]);
    dt_inc  = wide_t'({1'b0, dt_sum[48:1]});
    if (acc_r[PW-1]) begin
      dt_inc = -dt_inc;
    end
    dt_new  = wide_t'(q_r[cmd.idx]) + dt_inc;
    half_sh = (8'(sh_r) - (big ? 8'sd2 : 8'sd0)) >>> 1;
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_full;
    unique case (cmd.op)
      OP_LATCH: begin
        kind_r <= in_kind;
        c_r[0] <= in_comp_real;
        c_r[1] <= in_comp_i;
        c_r[2] <= in_comp_j;
        c_r[3] <= in_comp_k;
        w_r[0] <= in_omega_x;
        w_r[1] <= in_omega_y;
        w_r[2] <= in_omega_z;
        dt_r   <= in_step_time;
        wz_r   <= 1'b0;
        sat_r  <= 1'b0;
      end
      OP_SQ_ACC: begin
        acc_r <= (cmd.idx == 2'd0) ? prod_r : acc_r + prod_r;
      end
      OP_NORM_INIT: begin
        dn_r <= big ? acc_r[65:2] : acc_r[63:0];
        sh_r <= '0;
      end
      OP_NORM_STEP: begin
        priority if (dn_r[63:62] != 2'b00) begin
          dn_r <= dn_r >> 2;
          sh_r <= sh_r - 7'sd2;
        end else if (dn_r[63:54] == 10'd0) begin
          dn_r <= dn_r << 8;
          sh_r <= sh_r + 7'sd8;
        end else begin
          dn_r <= dn_r << 2;
          sh_r <= sh_r + 7'sd2;
        end
      end
      OP_SEED: begin
        m_r   <= dn_r[61:30];
        y_r   <= dn_r[61] ? SEED_LARGE_M : SEED_SMALL_M;
        rsh_r <= 6'(8'sd30 - half_sh);
      end
      OP_NT_B: tmp_r <= prod_r[61:30];
      OP_NT_D: tmp_r <= (nt_t < THREE_Q30) ? 32'(THREE_Q30 - nt_t) : 32'd0;
      OP_NT_F: y_r <= nt_q[31] ? 31'h7FFF_FFFF : nt_q[30:0];
      OP_SC_WR: begin
        nq_r[cmd.idx] <= clip_val(sc_s);
        sat_r         <= sat_r | clip_ovf(sc_s);
      end
      OP_ZERO: begin
        nq_r[0] <= clip_val(ONE_Q30);
        nq_r[1] <= '0;
        nq_r[2] <= '0;
        nq_r[3] <= '0;
        sat_r   <= clip_ovf(ONE_Q30);
        wz_r    <= 1'b1;
      end
      OP_RT_ACC: begin
        acc_r <= (cmd.term == 2'd0) ? rt_term : acc_r + rt_term;
      end
      OP_DT_HI: hi_r <= prod_r[47:0];
      OP_DT_WR: begin
        nq_r[cmd.idx] <= clip_val(dt_new);
        sat_r         <= sat_r | clip_ovf(dt_new);
      end
      OP_COMMIT: begin
        out_zero_r <= wz_r;
        out_sat_r  <= sat_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < 4; n++) begin
        q_r[n] <= '0;
      end
    end else if (cmd.op == OP_COMMIT) begin
      for (int n = 0; n < 4; n++) begin
        q_r[n] <= nq_r[n];
      end
    end
  end

  assign out_real      = 32'(q_r[0]);
  assign out_i         = 32'(q_r[1]);
  assign out_j         = 32'(q_r[2]);
  assign out_k         = 32'(q_r[3]);
  assign out_was_zero  = out_zero_r;
  assign out_saturated = out_sat_r;

endmodule
`default_nettype wire

// ===== hdl/quaternion_orientation_integrator_unit.sv =====
// Top level of the quaternion orientation integrator.
//
// Input channel in_valid/in_ready carries one transaction per item: in_kind 0
// loads and normalizes in_comp_*, in_kind 1 integrates one step of in_omega_*
// over in_step_time. Every item yields exactly one transaction on the output
// channel out_valid/out_ready with the stored quaternion and two flags.
// One shared 33x33 multiplier, reused by a sequencer, does all products; a
// result is registered after every product before it is used.
// An integrate item accumulates the Hamilton product terms of each component,
// scales the sum by in_step_time and adds it to the component. A load squares
// and sums the components, normalizes the sum with 0 to 9 two-bit or eight-bit
// shifts, runs NORM_ITERATIONS Newton iterations and scales each component;
// an all-zero load writes the identity quaternion instead.
// in_ready is high only while the sequencer is idle, which it enters after
// each result is committed. The next transaction is accepted as soon as the
// previous result sits in the output register, even if the receiver has not
// taken it. A stalled receiver holds the finished result and, once a second
// item is done, holds the sequencer until taken.
// Synchronous reset clears the orientation to zero and drops out_valid.
`default_nettype none
module quaternion_orientation_integrator_unit #(
  parameter int COMPONENT_WIDTH = qoi_pkg::QOI_COMPONENT_WIDTH,
  parameter int NORM_ITERATIONS = qoi_pkg::QOI_NORM_ITERATIONS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic signed [31:0] in_comp_real,
  input  logic signed [31:0] in_comp_i,
  input  logic signed [31:0] in_comp_j,
  input  logic signed [31:0] in_comp_k,
  input  logic signed [31:0] in_omega_x,
  input  logic signed [31:0] in_omega_y,
  input  logic signed [31:0] in_omega_z,
  input  logic        [23:0] in_step_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_real,
  output logic signed [31:0] out_i,
  output logic signed [31:0] out_j,
  output logic signed [31:0] out_k,
  output logic               out_was_zero,
  output logic               out_saturated
);
  import qoi_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  qoi_ctrl #(
    .NORM_ITERATIONS(NORM_ITERATIONS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  qoi_datapath #(
    .COMPONENT_WIDTH(COMPONENT_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_kind       (in_kind),
    .in_comp_real  (in_comp_real),
    .in_comp_i     (in_comp_i),
    .in_comp_j     (in_comp_j),
    .in_comp_k     (in_comp_k),
    .in_omega_x    (in_omega_x),
    .in_omega_y    (in_omega_y),
    .in_omega_z    (in_omega_z),
    .in_step_time  (in_step_time),
    .out_real      (out_real),
    .out_i         (out_i),
    .out_j         (out_j),
    .out_k         (out_k),
    .out_was_zero  (out_was_zero),
    .out_saturated (out_saturated)
  );

endmodule
`default_nettype wire

// ===== hdl/qoi_checker.sv =====
// Port-level checker for the quaternion orientation integrator and its bind.
`default_nettype none
`include "quaternion_orientation_integrator_unit_assert.svh"
module qoi_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [31:0] out_real,
  input wire logic signed [31:0] out_i,
  input wire logic signed [31:0] out_j,
  input wire logic signed [31:0] out_k,
  input wire logic               out_was_zero,
  input wire logic               out_saturated
);

  `QOI_ASSERT_NEXT_ALWAYS(a_reset_clears_valid, clk, !rst_n, !out_valid)

  `QOI_ASSERT_NEXT(a_one_item_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

  `QOI_ASSERT_NOW(a_zero_load_is_identity, clk, rst_n, out_valid && out_was_zero,
    out_i == 32'sd0 && out_j == 32'sd0 && out_k == 32'sd0 && !out_real[31])

  `QOI_ASSERT_NEXT(a_result_held_while_stalled, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_real) && $stable(out_i) && $stable(out_j) &&
    $stable(out_k) && $stable(out_was_zero) && $stable(out_saturated))

endmodule

bind quaternion_orientation_integrator_unit qoi_checker u_qoi_checker (.*);
`default_nettype wire

// ===== test/quaternion_orientation_integrator_unit_tb.sv =====
// Self-checking testbench for the quaternion orientation integrator with random handshake gaps.
`timescale 1ns / 1ps
module quaternion_orientation_integrator_unit_tb;

  typedef struct packed {
    logic [31:0] q_real;
    logic [31:0] q_i;
    logic [31:0] q_j;
    logic [31:0] q_k;
    logic        was_zero;
    logic        saturated;
  } attitude_t;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_INTEGRATE = 1'b1;
  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_kind;
  logic signed [31:0] in_comp_real, in_comp_i, in_comp_j, in_comp_k;
  logic signed [31:0] in_omega_x, in_omega_y, in_omega_z;
  logic [23:0] in_step_time;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] out_real, out_i, out_j, out_k;
  logic out_was_zero, out_saturated;

  attitude_t expected_attitudes[$];
  longint attitude[4];
  int mismatch_count;
  int idle_cycles;

  quaternion_orientation_integrator_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_comp_real(in_comp_real), .in_comp_i(in_comp_i),
    .in_comp_j(in_comp_j), .in_comp_k(in_comp_k), .in_omega_x(in_omega_x),
    .in_omega_y(in_omega_y), .in_omega_z(in_omega_z), .in_step_time(in_step_time),
    .out_valid(out_valid), .out_ready(out_ready), .out_real(out_real), .out_i(out_i),
    .out_j(out_j), .out_k(out_k), .out_was_zero(out_was_zero),
    .out_saturated(out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 120);
  endfunction

  function automatic longint clip_component(longint x, ref bit sat);
    if (x > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic longint rate_product(longint a, longint w);
    return (a * w) >>> 16;
  endfunction

  function automatic void normalize_load(input logic signed [31:0] c[4], ref bit zero,
                                         ref bit sat);
    logic [63:0] mag[4];
    logic [63:0] sq, sum, low, dn, m, y, y2, t, f;
    bit big, all_zero;
    int p, sh, h, rsh;
    big = 1'b0;
    all_zero = 1'b1;
    sum = '0;
    low = '0;
    for (int n = 0; n < 4; n++) begin
      mag[n] = (c[n] < 0) ? 64'(-longint'(c[n])) : 64'(longint'(c[n]));
      if (c[n] != 0) all_zero = 1'b0;
      if (mag[n] >= 64'd1 << 30) big = 1'b1;
    end
    if (all_zero) begin
      zero = 1'b1;
      attitude[0] = 64'sd1 << 30;
      for (int n = 1; n < 4; n++) attitude[n] = 0;
      return;
    end
    for (int n = 0; n < 4; n++) begin
      sq = mag[n] * mag[n];
      if (big) begin
        sum += sq >> 2;
        low += sq & 64'd3;
      end else begin
        sum += sq;
      end
    end
    if (big) sum += low >> 2;
    p = 63;
    while (p > 0 && !sum[p]) p--;
    sh = (p % 2 == 1) ? 61 - p : 60 - p;
    dn = (sh >= 0) ? sum << sh : sum >> (-sh);
    h = (sh - (big ? 2 : 0)) / 2;
    rsh = 30 - h;
    m = dn >> 30;
    y = (m < 64'd1 << 31) ? 64'd912680550 : 64'd644245094;
    for (int it = 0; it < 4; it++) begin
      y2 = (y * y) >> 30;
      t = (m * y2) >> 30;
      f = (t < 64'd3 << 30) ? (64'd3 << 30) - t : 64'd0;
      y = (y * f) >> 31;
      if (y > 64'h7FFFFFFF) y = 64'h7FFFFFFF;
    end
    for (int n = 0; n < 4; n++) begin
      longint v;
      v = longint'((mag[n] * y) >> rsh);
      attitude[n] = clip_component((c[n] < 0) ? -v : v, sat);
    end
  endfunction

  function automatic void integrate_rate(longint wx, longint wy, longint wz,
                                         logic [23:0] dt, ref bit sat);
    longint a[4];
    longint s[4];
    logic [63:0] mg, hi, lo;
    longint inc;
    for (int n = 0; n < 4; n++) a[n] = attitude[n];
    s[0] = -rate_product(a[1], wx) - rate_product(a[2], wy) - rate_product(a[3], wz);
    s[1] = rate_product(a[0], wx) + rate_product(a[2], wz) - rate_product(a[3], wy);
    s[2] = rate_product(a[0], wy) + rate_product(a[3], wx) - rate_product(a[1], wz);
    s[3] = rate_product(a[0], wz) + rate_product(a[1], wy) - rate_product(a[2], wx);
    for (int n = 0; n < 4; n++) begin
      mg = (s[n] < 0) ? 64'(-s[n]) : 64'(s[n]);
      hi = (mg >> 24) * dt;
      lo = (mg & 64'hFFFFFF) * dt;
      inc = longint'((hi + (lo >> 24)) >> 1);
      if (s[n] < 0) inc = -inc;
      attitude[n] = clip_component(attitude[n] + inc, sat);
    end
  endfunction

  task automatic send_item(logic kind, logic signed [31:0] cr, logic signed [31:0] ci,
                           logic signed [31:0] cj, logic signed [31:0] ck,
                           logic signed [31:0] wx, logic signed [31:0] wy,
                           logic signed [31:0] wz, logic [23:0] dt);
    int gap;
    logic signed [31:0] comps[4];
    attitude_t exp_att;
    bit zero, sat;
    gap = gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_comp_real <= cr;
    in_comp_i <= ci;
    in_comp_j <= cj;
    in_comp_k <= ck;
    in_omega_x <= wx;
    in_omega_y <= wy;
    in_omega_z <= wz;
    in_step_time <= dt;
    do @(posedge clk); while (!in_ready);
    zero = 1'b0;
    sat = 1'b0;
    comps[0] = cr;
    comps[1] = ci;
    comps[2] = cj;
    comps[3] = ck;
    if (kind == KIND_INTEGRATE) integrate_rate(wx, wy, wz, dt, sat);
    else normalize_load(comps, zero, sat);
    exp_att.q_real = attitude[0][31:0];
    exp_att.q_i = attitude[1][31:0];
    exp_att.q_j = attitude[2][31:0];
    exp_att.q_k = attitude[3][31:0];
    exp_att.was_zero = zero;
    exp_att.saturated = sat;
    expected_attitudes.push_back(exp_att);
  endtask

  function automatic logic signed [31:0] rand_word();
    unique case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'($signed($urandom_range(0, 2047)) - 1024);
      3: return 32'($signed($urandom_range(0, 32'h7FFFFFFF)) >>> $urandom_range(0, 30));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] unit_comp();
    return 32'($signed($urandom_range(0, 32'h7FFFFFFF)) - 32'sh40000000);
  endfunction

  function automatic logic signed [31:0] rate_value();
    if ($urandom_range(0, 9) == 0) return rand_word();
    return 32'($signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000);
  endfunction

  task automatic test_directed_loads();
    send_item(KIND_INTEGRATE, 0, 0, 0, 0, 32'sh10000, 32'sh20000, -32'sh30000, 24'hFFFFFF);
    send_item(KIND_LOAD, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(KIND_LOAD, 32'sh40000000, 0, 0, 0, 0, 0, 0, 0);
    send_item(KIND_LOAD, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
              0, 0, 0, 0);
    send_item(KIND_LOAD, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
              -1, -1, -1, 24'hFFFFFF);
    send_item(KIND_LOAD, 1, 0, 0, 0, 0, 0, 0, 0);
    send_item(KIND_LOAD, 0, 0, 0, -1, 0, 0, 0, 0);
    send_item(KIND_LOAD, 32'sh3FFFFFFF, -32'sh3FFFFFFF, 32'sh00012345, 0, 0, 0, 0, 0);
    send_item(KIND_LOAD, 0, 32'sh80000000, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_directed_integrate();
    send_item(KIND_LOAD, 32'sh40000000, 0, 0, 0, 0, 0, 0, 0);
    send_item(KIND_INTEGRATE, 0, 0, 0, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
              24'hFFFFFF);
    send_item(KIND_INTEGRATE, 0, 0, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000,
              24'hFFFFFF);
    send_item(KIND_INTEGRATE, -1, -1, -1, -1, 32'sh80000000, 32'sh7FFFFFFF, 0,
              24'hFFFFFF);
    send_item(KIND_LOAD, 32'sh20000000, -32'sh20000000, 32'sh20000000, -32'sh20000000,
              0, 0, 0, 0);
    send_item(KIND_INTEGRATE, 0, 0, 0, 0, 32'sh00010000, -32'sh00008000, 32'sh00004000,
              24'h000000);
    send_item(KIND_INTEGRATE, 0, 0, 0, 0, -1, -1, -1, 24'h000001);
    send_item(KIND_INTEGRATE, 0, 0, 0, 0, 32'sh00030000, 32'sh00010000, -32'sh00020000,
              24'h00A000);
  endtask

  task automatic test_random_items(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 3)
        send_item(KIND_LOAD,
                  ($urandom_range(0, 3) == 0) ? rand_word() : unit_comp(),
                  ($urandom_range(0, 3) == 0) ? rand_word() : unit_comp(),
                  ($urandom_range(0, 3) == 0) ? rand_word() : unit_comp(),
                  ($urandom_range(0, 3) == 0) ? rand_word() : unit_comp(),
                  $urandom, $urandom, $urandom, 24'($urandom));
      else if ($urandom_range(0, 39) == 0)
        send_item(KIND_LOAD, 0, 0, 0, 0, $urandom, $urandom, $urandom, 24'($urandom));
      else
        send_item(KIND_INTEGRATE, $urandom, $urandom, $urandom, $urandom,
                  rate_value(), rate_value(), rate_value(),
                  ($urandom_range(0, 4) == 0) ? 24'($urandom) :
                  24'($urandom_range(0, 24'h03FFFF)));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if ($urandom_range(0, 9) < 7) out_ready <= ($urandom_range(0, 99) < 95);
      else out_ready <= ($urandom_range(0, 99) < 30);
    end
  end

  always @(posedge clk) begin
    attitude_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_real, out_i, out_j, out_k, out_was_zero, out_saturated};
      if (expected_attitudes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected output transaction %h", got);
      end else begin
        want = expected_attitudes.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected %h %h %h %h z%b s%b, got %h %h %h %h z%b s%b",
                     want.q_real, want.q_i, want.q_j, want.q_k, want.was_zero,
                     want.saturated, got.q_real, got.q_i, got.q_j, got.q_k,
                     got.was_zero, got.saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    out_ready <= 1'b0;
    in_kind <= 1'b0;
    in_comp_real <= '0;
    in_comp_i <= '0;
    in_comp_j <= '0;
    in_comp_k <= '0;
    in_omega_x <= '0;
    in_omega_y <= '0;
    in_omega_z <= '0;
    in_step_time <= '0;
    mismatch_count = 0;
    for (int n = 0; n < 4; n++) attitude[n] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_loads();
    test_directed_integrate();
    test_random_items(1533);
    in_valid <= 1'b0;
    while (expected_attitudes.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
